// ===== sv/fro_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fro_pkg
// Shared constants and helpers for the Fresnel refract/reflect selector.
// ============================================================================
package fro_pkg;

  localparam int DEF_FRAC_BITS = 14;
  localparam int DIR_W         = 16;
  localparam int IDX_W         = 16;
  localparam int RAND_W        = 16;
  localparam int PDF_W         = 15;

  // configuration register indexes
  localparam logic REG_INSIDE  = 1'b0;
  localparam logic REG_OUTSIDE = 1'b1;

  localparam logic [IDX_W-1:0] RST_INSIDE  = 16'd24576;
  localparam logic [IDX_W-1:0] RST_OUTSIDE = 16'd16384;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // signed value from magnitude and sign, saturated to 16 bits
  function automatic logic signed [15:0] pack16(input logic [31:0] mag, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = (mag >= 32'd32768) ? 16'h8000 : 16'(16'd0 - mag[15:0]);
    end else begin
      r = (mag >= 32'd32767) ? 16'h7FFF : mag[15:0];
    end
    return $signed(r);
  endfunction

endpackage

// ===== sv/fro_isqrt.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fro_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ============================================================================
module fro_isqrt #(
  parameter int IW  = 32,
  parameter int SDW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IW-1:0]     in_arg,
  input  logic [SDW-1:0]    in_side,
  output logic              out_valid,
  output logic [IW/2-1:0]   out_root,
  output logic [SDW-1:0]    out_side
);

  localparam int RW = IW / 2;
  localparam int MW = RW + 1;

  logic          vld  [RW];
  logic [MW-1:0] rem  [RW];
  logic [RW-1:0] root [RW];
  logic [IW-1:0] arg  [RW];
  logic [SDW-1:0] side [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic           s_v;
    logic [MW-1:0]  s_rem;
    logic [RW-1:0]  s_root;
    logic [IW-1:0]  s_arg;
    logic [SDW-1:0] s_side;
    logic [MW+1:0]  t;
    logic [MW+1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign s_v    = in_valid;
      assign s_rem  = '0;
      assign s_root = '0;
      assign s_arg  = in_arg;
      assign s_side = in_side;
    end else begin : g_next
      assign s_v    = vld[k-1];
      assign s_rem  = rem[k-1];
      assign s_root = root[k-1];
      assign s_arg  = arg[k-1];
      assign s_side = side[k-1];
    end

    assign t     = {s_rem, s_arg[IW-1 -: 2]};
    assign trial = (MW+2)'({s_root, 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? MW'(t - trial) : MW'(t);
        root[k] <= RW'({s_root, ge});
        arg[k]  <= s_arg << 2;
        side[k] <= s_side;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign out_root  = root[RW-1];
  assign out_side  = side[RW-1];

endmodule

// ===== sv/fro_divq.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fro_divq
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Quotient is floor((rem0 * 2^QW + tail) / den), rem0 below den.
// ============================================================================
module fro_divq #(
  parameter int DW  = 16,
  parameter int QW  = 16,
  parameter int SDW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [DW-1:0]  in_rem0,
  input  logic [QW-1:0]  in_tail,
  input  logic [DW-1:0]  in_den,
  input  logic [SDW-1:0] in_side,
  output logic           out_valid,
  output logic [QW-1:0]  out_quo,
  output logic [SDW-1:0] out_side
);

  logic           vld  [QW];
  logic [DW-1:0]  rem  [QW];
  logic [QW-1:0]  quo  [QW];
  logic [QW-1:0]  tail [QW];
  logic [DW-1:0]  den  [QW];
  logic [SDW-1:0] side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic           s_v;
    logic [DW-1:0]  s_rem;
    logic [QW-1:0]  s_quo;
    logic [QW-1:0]  s_tail;
    logic [DW-1:0]  s_den;
    logic [SDW-1:0] s_side;
    logic [DW:0]    t;
    logic           ge;

    if (k == 0) begin : g_first
      assign s_v    = in_valid;
      assign s_rem  = in_rem0;
      assign s_quo  = '0;
      assign s_tail = in_tail;
      assign s_den  = in_den;
      assign s_side = in_side;
    end else begin : g_next
      assign s_v    = vld[k-1];
      assign s_rem  = rem[k-1];
      assign s_quo  = quo[k-1];
      assign s_tail = tail[k-1];
      assign s_den  = den[k-1];
      assign s_side = side[k-1];
    end

    assign t  = {s_rem, s_tail[QW-1]};
    assign ge = t >= {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? DW'(t - {1'b0, s_den}) : DW'(t);
        quo[k]  <= QW'({s_quo, ge});
        tail[k] <= s_tail << 1;
        den[k]  <= s_den;
        side[k] <= s_side;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo[QW-1];
  assign out_side  = side[QW-1];

endmodule

// ===== sv/fresnel_refract_or_reflect.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fresnel_refract_or_reflect
// Dielectric Fresnel selector: index ratio, transmission probability and
// choice between refracted and mirror direction, in fixed point.
// ============================================================================
//  channel | signals                               | accepted when
//  --------+---------------------------------------+--------------------------
//  in      | in_valid, in_stall, dir_x/y/z, rand_u | in_valid && !in_stall
//  out     | out_valid, out_stall, out_x/y/z,      | out_valid && !out_stall
//          | choice_pdf, refracted, total_reflection
//  cfg     | cfg_we, cfg_index, cfg_data           | cfg_we
//
// One item per cycle while the output is not stalled. Pipeline depth is set by
// the hypot root, the eta divider, the cosine root and the ratio dividers.
// Reset clears all valid bits; index registers go to 1.5 and 1.0.
// A stall on the output with a full output register freezes the whole pipe.
// ============================================================================
module fresnel_refract_or_reflect
  import fro_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [IDX_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic [RAND_W-1:0]       rand_u,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [DIR_W-1:0] out_x,
  output logic signed [DIR_W-1:0] out_y,
  output logic signed [DIR_W-1:0] out_z,
  output logic [PDF_W-1:0]        choice_pdf,
  output logic                    refracted,
  output logic                    total_reflection
);

  localparam int F    = FRAC_BITS;
  localparam int EW   = 16 + F;
  localparam int RW   = (17 + F > 32) ? 17 + F : 32;
  localparam int DW   = RW + 1;
  localparam int CW   = 2 * F + 2;
  localparam int SA_W = 96;
  localparam int SB_W = 81;
  localparam int SC_W = EW + 129;
  localparam int SD_W = 132 + F;

  logic [IDX_W-1:0] inside_index;
  logic [IDX_W-1:0] outside_index;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_index  <= RST_INSIDE;
      outside_index <= RST_OUTSIDE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INSIDE:  inside_index  <= cfg_data;
        REG_OUTSIDE: outside_index <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // input stage
  logic               s1_v;
  logic signed [15:0] s1_x, s1_y, s1_z;
  logic [15:0]        s1_u, s1_num, s1_den;
  logic [15:0]        s1_ax, s1_ay;
  logic [31:0]        s1_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x   <= dir_x;
      s1_y   <= dir_y;
      s1_z   <= dir_z;
      s1_u   <= rand_u;
      s1_num <= (dir_z < 0) ? inside_index : outside_index;
      s1_den <= (dir_z < 0) ? outside_index : inside_index;
    end
  end

  assign s1_ax = mag16(s1_x);
  assign s1_ay = mag16(s1_y);
  assign s1_sq = 32'(s1_ax) * 32'(s1_ax) + 32'(s1_ay) * 32'(s1_ay);

  // hypot root
  logic               a_v;
  logic [15:0]        a_hyp;
  logic [SA_W-1:0]    a_side;
  logic signed [15:0] a_x, a_y, a_z;
  logic [15:0]        a_u, a_num, a_den;

  fro_isqrt #(.IW(32), .SDW(SA_W)) u_hyp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_v), .in_arg(s1_sq),
    .in_side({s1_x, s1_y, s1_z, s1_u, s1_num, s1_den}),
    .out_valid(a_v), .out_root(a_hyp), .out_side(a_side)
  );

  assign {a_x, a_y, a_z, a_u, a_num, a_den} = a_side;

  // eta divider
  logic               b_v;
  logic [EW-1:0]      b_q;
  logic [SB_W-1:0]    b_side;
  logic signed [15:0] b_x, b_y, b_z;
  logic [15:0]        b_u, b_hyp;
  logic               b_dz;
  logic [EW-1:0]      b_eta;

  fro_divq #(.DW(16), .QW(EW), .SDW(SB_W)) u_eta (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_v), .in_rem0(16'd0), .in_tail({a_num, {F{1'b0}}}), .in_den(a_den),
    .in_side({a_x, a_y, a_z, a_u, a_hyp, a_den == 16'd0}),
    .out_valid(b_v), .out_quo(b_q), .out_side(b_side)
  );

  assign {b_x, b_y, b_z, b_u, b_hyp, b_dz} = b_side;
  assign b_eta = b_dz ? {16'hFFFF, {F{1'b0}}} : b_q;

  // products with eta
  logic               s2_v;
  logic [EW-1:0]      s2_eta;
  logic [EW+15:0]     s2_ps, s2_px, s2_py;
  logic signed [15:0] s2_x, s2_y, s2_z;
  logic [15:0]        s2_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_eta <= b_eta;
      s2_ps  <= (EW+16)'(b_hyp) * (EW+16)'(b_eta);
      s2_px  <= (EW+16)'(mag16(b_x)) * (EW+16)'(b_eta);
      s2_py  <= (EW+16)'(mag16(b_y)) * (EW+16)'(b_eta);
      s2_x   <= b_x;
      s2_y   <= b_y;
      s2_z   <= b_z;
      s2_u   <= b_u;
    end
  end

  // sin_t, total reflection
  logic               s3_v;
  logic               s3_tir;
  logic [2*F-1:0]     s3_sin2;
  logic [31:0]        s3_mx, s3_my;
  logic [EW-1:0]      s3_eta;
  logic signed [15:0] s3_x, s3_y, s3_z;
  logic [15:0]        s3_u;
  logic [F-1:0]       s2_sin;
  logic [CW-1:0]      s3_carg;

  assign s2_sin = s2_ps[2*F-1:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tir  <= |s2_ps[EW+15:2*F];
      s3_sin2 <= (2*F)'(s2_sin) * (2*F)'(s2_sin);
      s3_mx   <= s2_px[EW+15:F];
      s3_my   <= s2_py[EW+15:F];
      s3_eta  <= s2_eta;
      s3_x    <= s2_x;
      s3_y    <= s2_y;
      s3_z    <= s2_z;
      s3_u    <= s2_u;
    end
  end

  assign s3_carg = s3_tir ? '0 : (CW'(1) << (2 * F)) - CW'(s3_sin2);

  // cos_t root
  logic               c_v;
  logic [F:0]         c_cos;
  logic [SC_W-1:0]    c_side;
  logic [EW-1:0]      c_eta;
  logic [31:0]        c_mx, c_my;
  logic signed [15:0] c_x, c_y, c_z;
  logic [15:0]        c_u;
  logic               c_tir;

  fro_isqrt #(.IW(CW), .SDW(SC_W)) u_cos (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s3_v), .in_arg(s3_carg),
    .in_side({s3_eta, s3_mx, s3_my, s3_x, s3_y, s3_z, s3_u, s3_tir}),
    .out_valid(c_v), .out_root(c_cos), .out_side(c_side)
  );

  assign {c_eta, c_mx, c_my, c_x, c_y, c_z, c_u, c_tir} = c_side;

  // Fresnel terms
  logic               s5_v;
  logic [F:0]         s5_cos;
  logic [EW+F:0]      s5_pb;
  logic [EW+15:0]     s5_pa;
  logic [31:0]        s5_mx, s5_my;
  logic signed [15:0] s5_x, s5_y, s5_z;
  logic [15:0]        s5_u;
  logic               s5_tir;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_cos <= c_cos;
      s5_pb  <= (EW+F+1)'(c_eta) * (EW+F+1)'(c_cos);
      s5_pa  <= (EW+16)'(c_eta) * (EW+16)'(mag16(c_z));
      s5_mx  <= c_mx;
      s5_my  <= c_my;
      s5_x   <= c_x;
      s5_y   <= c_y;
      s5_z   <= c_z;
      s5_u   <= c_u;
      s5_tir <= c_tir;
    end
  end

  logic [RW-1:0] s5_as, s5_bs, s5_ap, s5_bp;

  assign s5_as = RW'(mag16(s5_z));
  assign s5_bs = RW'(s5_pb[EW+F:F]);
  assign s5_ap = RW'(s5_pa[EW+15:F]);
  assign s5_bp = RW'(s5_cos);

  logic               s6_v;
  logic [DW-1:0]      s6_ds, s6_ns, s6_dp, s6_np;
  logic [31:0]        s6_mx, s6_my;
  logic signed [15:0] s6_x, s6_y, s6_z;
  logic [15:0]        s6_u;
  logic               s6_tir;
  logic [F:0]         s6_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_ds  <= DW'(s5_as) + DW'(s5_bs);
      s6_ns  <= (s5_as >= s5_bs) ? DW'(s5_as - s5_bs) : DW'(s5_bs - s5_as);
      s6_dp  <= DW'(s5_ap) + DW'(s5_bp);
      s6_np  <= (s5_ap >= s5_bp) ? DW'(s5_ap - s5_bp) : DW'(s5_bp - s5_ap);
      s6_mx  <= s5_mx;
      s6_my  <= s5_my;
      s6_x   <= s5_x;
      s6_y   <= s5_y;
      s6_z   <= s5_z;
      s6_u   <= s5_u;
      s6_tir <= s5_tir;
      s6_cos <= s5_cos;
    end
  end

  // integer bit of each ratio, remainder goes on to the dividers
  logic          s6_ges, s6_gep;
  logic [DW-1:0] s6_rems, s6_remp;

  assign s6_ges  = s6_ns >= s6_ds;
  assign s6_gep  = s6_np >= s6_dp;
  assign s6_rems = s6_ges ? DW'(s6_ns - s6_ds) : s6_ns;
  assign s6_remp = s6_gep ? DW'(s6_np - s6_dp) : s6_np;

  logic               e_vs, e_vp, e_v;
  logic [F-1:0]       e_qs, e_qp;
  logic [SD_W-1:0]    e_sides;
  logic [1:0]         e_sidep;
  logic               e_ges, e_dzs, e_gep, e_dzp;
  logic [31:0]        e_mx, e_my;
  logic signed [15:0] e_x, e_y, e_z;
  logic [15:0]        e_u;
  logic               e_tir;
  logic [F:0]         e_cos;

  fro_divq #(.DW(DW), .QW(F), .SDW(SD_W)) u_rs (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s6_v), .in_rem0(s6_rems), .in_tail('0), .in_den(s6_ds),
    .in_side({s6_ges, s6_ds == '0, s6_mx, s6_my, s6_x, s6_y, s6_z, s6_u,
              s6_tir, s6_cos}),
    .out_valid(e_vs), .out_quo(e_qs), .out_side(e_sides)
  );

  fro_divq #(.DW(DW), .QW(F), .SDW(2)) u_rp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s6_v), .in_rem0(s6_remp), .in_tail('0), .in_den(s6_dp),
    .in_side({s6_gep, s6_dp == '0}),
    .out_valid(e_vp), .out_quo(e_qp), .out_side(e_sidep)
  );

  assign {e_ges, e_dzs, e_mx, e_my, e_x, e_y, e_z, e_u, e_tir, e_cos} = e_sides;
  assign {e_gep, e_dzp} = e_sidep;
  assign e_v = e_vs & e_vp;

  // squared ratios
  logic               s7_v;
  logic [2*F+1:0]     s7_sqs, s7_sqp;
  logic               s7_dzs, s7_dzp;
  logic [31:0]        s7_mx, s7_my;
  logic signed [15:0] s7_x, s7_y, s7_z;
  logic [15:0]        s7_u;
  logic               s7_tir;
  logic [F:0]         s7_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sqs <= (2*F+2)'({e_ges, e_qs}) * (2*F+2)'({e_ges, e_qs});
      s7_sqp <= (2*F+2)'({e_gep, e_qp}) * (2*F+2)'({e_gep, e_qp});
      s7_dzs <= e_dzs;
      s7_dzp <= e_dzp;
      s7_mx  <= e_mx;
      s7_my  <= e_my;
      s7_x   <= e_x;
      s7_y   <= e_y;
      s7_z   <= e_z;
      s7_u   <= e_u;
      s7_tir <= e_tir;
      s7_cos <= e_cos;
    end
  end

  // transmission probability and choice
  logic [F:0]   one_f;
  logic [F:0]   s7_rs, s7_rp, s7_half, s7_p;
  logic [F+1:0] s7_sum;
  logic         s7_take;

  assign one_f   = (F+1)'(1) << F;
  assign s7_rs   = s7_dzs ? one_f : s7_sqs[2*F:F];
  assign s7_rp   = s7_dzp ? one_f : s7_sqp[2*F:F];
  assign s7_sum  = (F+2)'(s7_rs) + (F+2)'(s7_rp);
  assign s7_half = s7_sum[F+1:1];
  assign s7_p    = s7_tir ? '0 : (one_f - s7_half);
  assign s7_take = (F+17)'({s7_u, {F{1'b0}}}) < (F+17)'({s7_p, 16'd0});

  logic               s8_v;
  logic [F:0]         s8_p;
  logic               s8_take;
  logic [31:0]        s8_mx, s8_my;
  logic signed [15:0] s8_x, s8_y, s8_z;
  logic               s8_tir;
  logic [F:0]         s8_cos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= s7_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_p    <= s7_p;
      s8_take <= s7_take;
      s8_mx   <= s7_mx;
      s8_my   <= s7_my;
      s8_x    <= s7_x;
      s8_y    <= s7_y;
      s8_z    <= s7_z;
      s8_tir  <= s7_tir;
      s8_cos  <= s7_cos;
    end
  end

  // output register
  logic [F:0]    s8_pdf;
  logic [F+15:0] s8_pdf_ext;

  assign s8_pdf     = s8_take ? s8_p : (one_f - s8_p);
  assign s8_pdf_ext = (F+16)'(s8_pdf);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s8_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s8_take) begin
        out_x <= pack16(s8_mx, s8_x > 0);
        out_y <= pack16(s8_my, s8_y > 0);
        out_z <= (s8_z == 0) ? 16'sd0 : pack16(32'(s8_cos), s8_z > 0);
      end else begin
        out_x <= pack16(32'(mag16(s8_x)), s8_x > 0);
        out_y <= pack16(32'(mag16(s8_y)), s8_y > 0);
        out_z <= pack16(32'(mag16(s8_z)), s8_z < 0);
      end
      choice_pdf       <= s8_pdf_ext[PDF_W-1:0];
      refracted        <= s8_take;
      total_reflection <= s8_tir;
    end
  end

endmodule

// ===== dv/fresnel_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fresnel_checker
// Watches the config port and both item channels of the Fresnel selector,
// predicts each result from the accepted input item and the current index
// registers, and compares each whole result item with its prediction in order.
// ============================================================================
module fresnel_checker
  import fro_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [IDX_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [DIR_W-1:0] dir_x,
  input  logic signed [DIR_W-1:0] dir_y,
  input  logic signed [DIR_W-1:0] dir_z,
  input  logic [RAND_W-1:0]       rand_u,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [DIR_W-1:0] out_x,
  input  logic signed [DIR_W-1:0] out_y,
  input  logic signed [DIR_W-1:0] out_z,
  input  logic [PDF_W-1:0]        choice_pdf,
  input  logic                    refracted,
  input  logic                    total_reflection,
  output int                      errors,
  output int                      pending
);
  localparam int F = DEF_FRAC_BITS;

  typedef struct packed {
    logic [15:0] x, y, z;
    logic [14:0] pdf;
    logic        refr;
    logic        tir;
  } ray_t;

  ray_t        expected_rays[$];
  logic [15:0] idx_in, idx_out;

  assign pending = expected_rays.size();

  function automatic longint unsigned sqrt_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned reflectance(input longint unsigned a,
                                                  input longint unsigned b);
    longint unsigned d, n, r, rem;
    d = a + b;
    n = (a >= b) ? a - b : b - a;
    if (d == 0) return 64'd1 << F;
    r = (n >= d) ? 1 : 0;
    rem = (n >= d) ? n - d : n;
    for (int i = 0; i < F; i++) begin
      rem <<= 1;
      r <<= 1;
      if (rem >= d) begin
        rem -= d;
        r |= 1;
      end
    end
    return (r * r) >> F;
  endfunction

  function automatic logic [15:0] signed_sat(input longint unsigned m, input logic neg);
    if (neg) return (m >= 32768) ? 16'h8000 : 16'(-longint'(m));
    return (m >= 32767) ? 16'h7FFF : m[15:0];
  endfunction

  function automatic ray_t scatter_ray(input logic signed [15:0] x, y, z,
                                       input logic [15:0] u);
    longint unsigned one, ax, ay, ci, num, den, eta, hyp, sin_t, cos_t, p, rs, rp;
    logic tir, take;
    ray_t r;
    one = 64'd1 << F;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    ci = (z < 0) ? -longint'(z) : longint'(z);
    num = (z < 0) ? idx_in : idx_out;
    den = (z < 0) ? idx_out : idx_in;
    eta = (den == 0) ? (64'hFFFF << F) : (num << F) / den;
    hyp = sqrt_floor(ax * ax + ay * ay);
    sin_t = (hyp * eta) >> F;
    tir = sin_t >= one;
    cos_t = 0;
    p = 0;
    if (!tir) begin
      cos_t = sqrt_floor((one << F) - sin_t * sin_t);
      rs = reflectance(ci, (eta * cos_t) >> F);
      rp = reflectance((eta * ci) >> F, cos_t);
      p = one - ((rs + rp) >> 1);
    end
    take = (longint'(u) << F) < (p << 16);
    if (take) begin
      r.x = signed_sat((eta * ax) >> F, x > 0);
      r.y = signed_sat((eta * ay) >> F, y > 0);
      r.z = (z == 0) ? 16'd0 : signed_sat(cos_t, z > 0);
      r.pdf = p[14:0];
    end else begin
      r.x = signed_sat(ax, x > 0);
      r.y = signed_sat(ay, y > 0);
      r.z = signed_sat(ci, z < 0);
      r.pdf = 15'(one - p);
    end
    r.refr = take;
    r.tir = tir;
    return r;
  endfunction

  always @(posedge clk) begin
    ray_t e, a;
    if (rst) begin
      idx_in <= RST_INSIDE;
      idx_out <= RST_OUTSIDE;
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        a = '{out_x, out_y, out_z, choice_pdf, refracted, total_reflection};
        if (expected_rays.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %p", a);
        end else begin
          e = expected_rays.pop_front();
          if (a !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", e, a);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_rays = {expected_rays, scatter_ray(dir_x, dir_y, dir_z, rand_u)};
      if (cfg_we) begin
        if (cfg_index == REG_INSIDE) idx_in <= cfg_data;
        else idx_out <= cfg_data;
      end
    end
  end
endmodule

// ===== dv/fresnel_refract_or_reflect_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// fresnel_refract_or_reflect_test
// Drives directed and random rays through the Fresnel selector under several
// index settings with random idling and a long output hold-off; the checker
// beside the block predicts and compares every result item.
// ============================================================================
module fresnel_refract_or_reflect_test;
  import fro_pkg::*;

  logic clk, rst, cfg_we, cfg_index, in_valid, in_stall, out_valid, out_stall;
  logic [IDX_W-1:0] cfg_data;
  logic signed [DIR_W-1:0] dir_x, dir_y, dir_z, out_x, out_y, out_z;
  logic [RAND_W-1:0] rand_u;
  logic [PDF_W-1:0] choice_pdf;
  logic refracted, total_reflection;
  int errors, pending;
  logic quiet, hold;

  fresnel_refract_or_reflect dut (.*);
  fresnel_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, one long hold-off, a quiet stretch
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold) out_stall <= 1;
      else out_stall <= !quiet && ($urandom_range(99) < 27);
    end
  end

  task automatic send_ray(input logic [15:0] x, y, z, u);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    rand_u <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_index(input logic which, input logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= which;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] rand_comp();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'(-16384);
    if (k == 2) return 16'd16384;
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic random_rays(input int n);
    logic [15:0] x, y, z;
    int r;
    for (int i = 0; i < n; i++) begin
      // components no larger than 16384 in magnitude most of the time
      r = $urandom_range(16384);
      x = 16'($signed($urandom_range(2 * r)) - r);
      y = 16'($signed($urandom_range(2 * 12000)) - 12000);
      z = $urandom_range(1) ? 16'(r) : 16'(-r);
      if ($urandom_range(3) == 0) begin
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
      end
      send_ray(x, y, z, 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] ins[5], outs[5];
    ins = '{16'd24576, 16'd65535, 16'd8192, 16'd0, 16'd21800};
    outs = '{16'd16384, 16'd8192, 16'd65535, 16'd16384, 16'd0};
    rst = 1; cfg_we = 0; cfg_index = REG_INSIDE; cfg_data = '0;
    in_valid = 0; dir_x = '0; dir_y = '0; dir_z = '0; rand_u = '0;
    quiet = 0; hold = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: axes, grazing, extremes, total reflection, rand_u limits
    send_ray(16'd0, 16'd0, 16'd16384, 16'd0);
    send_ray(16'd0, 16'd0, 16'd16384, 16'hFFFF);
    send_ray(16'd0, 16'd0, -16'sd16384, 16'd0);
    send_ray(16'd0, 16'd0, 16'd0, 16'd0);
    send_ray(16'd16384, 16'd0, 16'd0, 16'd0);
    send_ray(-16'sd16384, 16'd0, 16'd0, 16'hFFFF);
    send_ray(16'd11585, 16'd0, -16'sd11585, 16'd0);
    send_ray(16'd11585, 16'd0, 16'd11585, 16'h8000);
    send_ray(16'h8000, 16'h8000, 16'h8000, 16'd0);
    send_ray(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_ray(16'd0, -16'sd16384, 16'd1, 16'd0);
    send_ray(-16'sd6000, 16'd6000, -16'sd14000, 16'd100);
    send_ray(16'hFFFF, 16'h0001, 16'hFFFF, 16'd1);
    send_ray(16'd15000, -16'sd5000, 16'd3000, 16'd0);
    drain();
    for (int c = 0; c < 5; c++) begin
      set_index(REG_INSIDE, ins[c]);
      set_index(REG_OUTSIDE, outs[c]);
      send_ray(16'd0, 16'd0, 16'd16384, 16'd0);
      send_ray(16'd0, 16'd0, -16'sd16384, 16'd0);
      send_ray(16'd16384, 16'd0, 16'd0, 16'd0);
      if (c == 1) begin
        quiet = 1;
        random_rays(150);
        quiet = 0;
      end
      if (c == 2) begin
        fork
          begin
            hold = 1;
            repeat (400) @(posedge clk);
            hold = 0;
          end
          random_rays(200);
        join
      end
      random_rays(300);
      drain();
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/fro_pkg.sv
sv/fro_isqrt.sv
sv/fro_divq.sv
sv/fresnel_refract_or_reflect.sv
dv/fresnel_checker.sv
dv/fresnel_refract_or_reflect_test.sv
